// ----- hw/rtl/sidg_pkg.sv -----
`default_nettype none

package sidg_pkg;

  // identifier geometry
  localparam int unsigned IdChars = 26;
  localparam int unsigned DigitW  = 5;
  localparam int unsigned IdBits  = IdChars * DigitW;
  localparam int unsigned TsW     = 48;
  localparam int unsigned StateW  = 64;
  localparam int unsigned CodeW   = 7;
  localparam int unsigned PosW    = 5;

  localparam logic [PosW-1:0] LastPos = PosW'(IdChars - 1);

  // generator constants
  localparam logic [StateW-1:0] SeedReset   = 64'd1;
  localparam logic [StateW-1:0] ScrambleMul = 64'h2545F4914F6CDD1D;
  localparam int unsigned       ShiftA      = 12;
  localparam int unsigned       ShiftB      = 25;
  localparam int unsigned       ShiftC      = 27;

  // crockford base32 alphabet, first character in the top byte
  localparam logic [255:0] Alphabet = "0123456789ABCDEFGHJKMNPQRSTVWXYZ";

  typedef struct packed {
    logic [TsW-1:0] timestamp_ms;
  } req_t;

  typedef struct packed {
    logic [CodeW-1:0] char_code;
    logic [PosW-1:0]  char_position;
    logic             last_char;
  } char_t;

  // identifier handed to the serializer
  typedef struct packed {
    logic              valid;
    logic [IdBits-1:0] id;
  } load_t;

  // one xorshift64 step
  function automatic logic [StateW-1:0] xs_step(logic [StateW-1:0] x);
    logic [StateW-1:0] a;
    logic [StateW-1:0] b;
    a = x ^ (x >> ShiftA);
    b = a ^ (a << ShiftB);
    return b ^ (b >> ShiftC);
  endfunction

  // ascii code of one base32 digit
  function automatic logic [CodeW-1:0] digit_char(logic [DigitW-1:0] d);
    logic [7:0] base;
    base = {~d, 3'b000};
    return Alphabet[base +: CodeW];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sidg_stream_if.sv -----
`default_nettype none

interface sidg_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/sidg_ser.sv -----
`default_nettype none

module sidg_ser (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  sidg_pkg::load_t     ld_i,
  output logic                ld_ready_o,
  sidg_stream_if.source       out_o
);

  logic                                busy_q, busy_d;
  logic [sidg_pkg::PosW-1:0]           cnt_q, cnt_d;
  logic [sidg_pkg::IdBits-1:0]         id_q, id_d;
  logic                                o_vld_q, o_vld_d;
  sidg_pkg::char_t                     o_data_q, o_data_d;
  logic                                emit;
  logic                                at_last;

  // a character moves to the output register when it is free
  assign emit       = busy_q && (!o_vld_q || out_o.ready);
  assign at_last    = (cnt_q == sidg_pkg::LastPos);
  assign ld_ready_o = !busy_q || (emit && at_last);

  // shift register and character counter
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    id_d   = id_q;
    if (emit) begin
      id_d  = id_q << sidg_pkg::DigitW;
      cnt_d = cnt_q + 1'b1;
      if (at_last) begin
        busy_d = 1'b0;
      end
    end
    if (ld_i.valid && ld_ready_o) begin
      id_d   = ld_i.id;
      cnt_d  = '0;
      busy_d = 1'b1;
    end
  end

  // output register
  always_comb begin
    o_vld_d  = o_vld_q;
    o_data_d = o_data_q;
    if (emit) begin
      o_vld_d                = 1'b1;
      o_data_d.char_code     = sidg_pkg::digit_char(
                                 id_q[sidg_pkg::IdBits-1 -: sidg_pkg::DigitW]);
      o_data_d.char_position = cnt_q;
      o_data_d.last_char     = at_last;
    end else if (out_o.ready) begin
      o_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      cnt_q   <= '0;
      o_vld_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      cnt_q   <= cnt_d;
      o_vld_q <= o_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q     <= id_d;
    o_data_q <= o_data_d;
  end

  assign out_o.valid = o_vld_q;
  assign out_o.data  = o_data_q;

endmodule

`default_nettype wire

// ----- hw/rtl/sortable_id_generator_base32_core.sv -----
// Sortable identifier generator with Crockford base32 text output.
// in_i carries one request per transfer: a 48-bit millisecond timestamp.
// out_o carries one ASCII character per transfer with its position; the
// 26th character of an identifier has last_char set.
// cfg_we_i/cfg_wdata_i load the 64-bit seed straight into the generator
// state; write it only while the block is idle. A zero seed locks the
// generator at zero.
// A request passes the request register and serializer shift register
// before its first character reaches out_o. Throughput: one character
// per cycle while out_o is ready, set by the single-character channel.
// Requests are taken while the previous identifier is still streaming: a
// request register holds the next one, and the generator steps three
// times in the cycle a request is taken.
// Reset: generator state returns to 1, all valid flags clear, no output.
// When the receiver stalls, the output character holds, the shift
// register stops, and the request side backs up through in_i.ready.
`default_nettype none

module sortable_id_generator_base32_core (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           cfg_we_i,
  input  wire  [63:0]   cfg_wdata_i,
  sidg_stream_if.sink   in_i,
  sidg_stream_if.source out_o
);

  logic [sidg_pkg::StateW-1:0] gen_q, gen_d;
  logic [sidg_pkg::StateW-1:0] x1, x2, x3;
  logic                        a_vld_q, a_vld_d;
  logic [sidg_pkg::TsW-1:0]    a_ts_q;
  logic [31:0]                 a_r1_q, a_r2_q;
  logic [15:0]                 a_r3_q;
  logic [31:0]                 p1, p2;
  logic [15:0]                 p3;
  logic                        accept;
  logic                        ld_ready;
  sidg_pkg::load_t             ld;

  // three generator steps per request
  assign x1 = sidg_pkg::xs_step(gen_q);
  assign x2 = sidg_pkg::xs_step(x1);
  assign x3 = sidg_pkg::xs_step(x2);

  assign in_i.ready = !a_vld_q || ld_ready;
  assign accept     = in_i.valid && in_i.ready;

  // generator state and request register valid
  always_comb begin
    gen_d   = gen_q;
    a_vld_d = a_vld_q;
    if (ld_ready) begin
      a_vld_d = 1'b0;
    end
    if (accept) begin
      gen_d   = x3;
      a_vld_d = 1'b1;
    end
    if (cfg_we_i) begin
      gen_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q   <= sidg_pkg::SeedReset;
      a_vld_q <= 1'b0;
    end else begin
      gen_q   <= gen_d;
      a_vld_q <= a_vld_d;
    end
  end

  // request payload with raw generator outputs
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_ts_q <= in_i.data.timestamp_ms;
      a_r1_q <= x1[31:0];
      a_r2_q <= x2[31:0];
      a_r3_q <= x3[15:0];
    end
  end

  // scramble: only the low bits of each product are kept
  assign p1 = a_r1_q * sidg_pkg::ScrambleMul[31:0];
  assign p2 = a_r2_q * sidg_pkg::ScrambleMul[31:0];
  assign p3 = a_r3_q * sidg_pkg::ScrambleMul[15:0];

  assign ld.valid = a_vld_q;
  assign ld.id    = {2'b00, a_ts_q, p1, p2, p3};

  sidg_ser u_ser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ld_i       (ld),
    .ld_ready_o (ld_ready),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

// ----- dv/sortable_id_generator_base32_core_tb.sv -----
`timescale 1ns / 1ps

module sortable_id_generator_base32_core_tb;

  // expected character stream for the identifiers taken so far
  class id_scoreboard;
    sidg_pkg::char_t expected_chars[$];
    logic [63:0]     gen_state;
    int unsigned     error_count;
    string           digits;

    function new();
      gen_state   = 64'd1;
      error_count = 0;
      digits      = "0123456789ABCDEFGHJKMNPQRSTVWXYZ";
    endfunction

    function void load_seed(logic [63:0] seed);
      gen_state = seed;
    endfunction

    // xorshift64 step followed by the multiplicative scramble
    function logic [63:0] scramble_next();
      logic [63:0] x;
      x = gen_state;
      x = x ^ (x >> 12);
      x = x ^ (x << 25);
      x = x ^ (x >> 27);
      gen_state = x;
      return x * 64'h2545F4914F6CDD1D;
    endfunction

    // one request transfer: build the identifier and queue its 26 chars
    function void note_request(logic [47:0] ts);
      logic [63:0]     r1;
      logic [63:0]     r2;
      logic [63:0]     r3;
      logic [129:0]    id_bits;
      logic [4:0]      d;
      byte             ch;
      sidg_pkg::char_t c;
      int              k;
      r1 = scramble_next();
      r2 = scramble_next();
      r3 = scramble_next();
      id_bits = {2'b00, ts, r1[31:0], r2[31:0], r3[15:0]};
      for (k = 0; k < 26; k++) begin
        d = id_bits[129 - 5 * k -: 5];
        ch = digits.getc(int'(d));
        c.char_code     = ch[6:0];
        c.char_position = 5'(k);
        c.last_char     = (k == 25);
        expected_chars.push_back(c);
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    task report_mismatch(string msg);
      error_count++;
      $display("MISMATCH: %s", msg);
    endtask

    // compare one character transfer with the oldest expectation
    task check_char(sidg_pkg::char_t got);
      sidg_pkg::char_t exp_c;
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char %h pos %0d", got.char_code,
                                  got.char_position));
      end else begin
        exp_c = expected_chars.pop_front();
        if (got.char_code !== exp_c.char_code)
          report_mismatch($sformatf("char_code pos %0d: got %h exp %h",
                                    exp_c.char_position, got.char_code,
                                    exp_c.char_code));
        if (got.char_position !== exp_c.char_position)
          report_mismatch($sformatf("char_position: got %0d exp %0d",
                                    got.char_position, exp_c.char_position));
        if (got.last_char !== exp_c.last_char)
          report_mismatch($sformatf("last_char pos %0d: got %b exp %b",
                                    exp_c.char_position, got.last_char,
                                    exp_c.last_char));
      end
    endtask
  endclass

  localparam int StallLimit = 3000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [63:0] cfg_wdata;

  sidg_stream_if #(.payload_t(sidg_pkg::req_t))  req_if ();
  sidg_stream_if #(.payload_t(sidg_pkg::char_t)) char_if ();

  id_scoreboard sb;
  bit           tx_idle_on;
  bit           rx_idle_on;
  int           rx_hold_cycles;
  int           stall_cycles;

  sortable_id_generator_base32_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (req_if),
    .out_o       (char_if)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // offer one timestamp and wait for its transfer
  task automatic send_request(logic [47:0] ts);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 11) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid             <= 1'b1;
    req_if.data.timestamp_ms <= ts;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(ts);
  endtask

  task automatic end_burst();
    @(negedge clk);
    req_if.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // seed write, only with the block idle
  task automatic write_seed(logic [63:0] seed);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= seed;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.load_seed(seed);
  endtask

  function automatic logic [47:0] random_ts();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       return 48'd0;
      1:       return {48{1'b1}};
      2:       return 48'($urandom_range(0, 255));
      default: return r[47:0];
    endcase
  endfunction

  // character receiver with random stalls and an optional long hold-off
  initial begin
    int gap;
    char_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (rx_hold_cycles > 0) begin
        gap = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        gap = rx_idle_on ? $urandom_range(0, 11) : 0;
      end
      @(negedge clk);
      if (gap > 0) begin
        char_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      char_if.ready <= 1'b1;
      do @(posedge clk); while (!char_if.valid);
      sb.check_char(char_if.data);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (char_if.valid && char_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // main sequence
  initial begin
    logic [63:0] seed;
    int          phase;
    int          i;
    sb             = new();
    tx_idle_on     = 1'b1;
    rx_idle_on     = 1'b1;
    rx_hold_cycles = 0;
    stall_cycles   = 0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = 64'd0;
    req_if.valid   = 1'b0;
    req_if.data    = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset seed, field extremes and bit patterns
    send_request(48'd0);
    send_request({48{1'b1}});
    send_request(48'hAAAA_AAAA_AAAA);
    send_request(48'h5555_5555_5555);
    send_request(48'd1);
    send_request(48'h8000_0000_0000);
    end_burst();
    wait_idle();

    // all-ones seed
    write_seed({64{1'b1}});
    send_request({48{1'b1}});
    send_request(48'd0);
    send_request(48'h8000_0000_0000);
    end_burst();
    wait_idle();

    // zero seed locks the generator, random bits stay zero
    write_seed(64'd0);
    send_request(48'd0);
    send_request({48{1'b1}});
    send_request(48'h0123_4567_89AB);
    end_burst();
    wait_idle();

    // random phases, each with its own seed and idling mix
    for (phase = 0; phase < 8; phase++) begin
      seed = {$urandom, $urandom};
      if (phase == 3) seed = 64'h8000_0000_0000_0000;
      if (phase == 7) seed = 64'd1;
      if (seed == 64'd0) seed = 64'd1;
      tx_idle_on = (phase % 3 != 1);
      rx_idle_on = (phase % 4 != 2);
      write_seed(seed);
      for (i = 0; i < 50; i++) begin
        // long receiver hold-off while requests keep coming
        if (phase == 1 && i == 5) rx_hold_cycles = 300;
        send_request(random_ts());
      end
      end_burst();
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sortable_id_generator_base32_core.f -----
hw/rtl/sidg_pkg.sv
hw/rtl/sidg_stream_if.sv
hw/rtl/sidg_ser.sv
hw/rtl/sortable_id_generator_base32_core.sv
dv/sortable_id_generator_base32_core_tb.sv
